// ===== design/clc_pkg.sv =====
// Package for the character LCD controller.
// Shared constants, item codes and the structs passed between the core,
// the display RAM and the top level. No dependencies.
`timescale 1ns / 1ps

package clc_pkg;

  localparam int ROW_LENGTH_DEF = 40;
  localparam int RAM_DEPTH_DEF  = 80;

  // full display address: line * ROW_LENGTH + column, below 128
  localparam int ADDR_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] FN_CMD     = 3'd0;
  localparam logic [2:0] FN_DATA_WR = 3'd1;
  localparam logic [2:0] FN_STATUS  = 3'd2;
  localparam logic [2:0] FN_DATA_RD = 3'd3;
  localparam logic [2:0] FN_TICK    = 3'd4;
  localparam logic [2:0] FN_FETCH   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_BUSY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_BUSY = 2'd1;

  localparam logic [15:0] SHORT_BUSY_RST = 16'd39;
  localparam logic [15:0] CLEAR_BUSY_RST = 16'd1350;

  // mode flag bit positions
  localparam int FL_WIDE  = 0;
  localparam int FL_TWO   = 1;
  localparam int FL_BIG   = 2;
  localparam int FL_DISP  = 3;
  localparam int FL_CURS  = 4;
  localparam int FL_BLINK = 5;
  localparam logic [5:0] FLAGS_RST = 6'b000001;

  localparam logic [7:0] CLEAR_CHAR = 8'h20;
  localparam logic [7:0] ROW0_FILL  = 8'hff;
  localparam logic [7:0] ROW1_FILL  = 8'h00;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } clc_mem_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_res;
    logic       display_enabled;
    logic       cursor_shown;
    logic       cursor_blinks;
    logic       wide_bus;
    logic       two_rows;
    logic       big_font;
  } clc_res_t;

endpackage

// ===== design/clc_dram.sv =====
// Display RAM: synchronous memory with a registered read.
// Per-entry valid bits give the reset or clear fill for unwritten cells.
// Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_dram import clc_pkg::*; #(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  clc_mem_req_t req,
  output logic [7:0]   rdata
);

  localparam int IW = $clog2(RAM_DEPTH);
  localparam logic [ADDR_W:0] HALF = (ADDR_W + 1)'(RAM_DEPTH / 2);

  logic [7:0]           mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] valid_r;
  logic                 cleared_r;
  logic [7:0]           mem_q_r;
  logic [7:0]           fill_q_r;
  logic                 hit_q_r;
  logic [IW-1:0]        idx;

  assign idx = req.addr[IW-1:0];

  // clear invalidates every cell at once; unwritten cells then read as blanks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      cleared_r <= 1'b0;
    end else if (req.clr) begin
      valid_r   <= '0;
      cleared_r <= 1'b1;
    end else if (req.wr_en) begin
      valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[idx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q_r <= mem[idx];
      hit_q_r <= valid_r[idx];
      if (cleared_r) begin
        fill_q_r <= CLEAR_CHAR;
      end else if ({1'b0, req.addr} < HALF) begin
        fill_q_r <= ROW0_FILL;
      end else begin
        fill_q_r <= ROW1_FILL;
      end
    end
  end

  assign rdata = hit_q_r ? mem_q_r : fill_q_r;

endmodule

// ===== design/clc_core.sv =====
// Control core: command decode, cursor, mode flags, nibble assembly,
// busy counter and configuration registers; drives the display RAM port.
// Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_core import clc_pkg::*; #(
  parameter int ROW_LENGTH = ROW_LENGTH_DEF,
  parameter int RAM_DEPTH  = RAM_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  input  logic [7:0]           in_bus_data,
  input  logic [1:0]           in_view_row,
  input  logic [5:0]           in_view_col,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output clc_mem_req_t         mem_req,
  input  logic [7:0]           mem_rdata,
  output clc_res_t             res,
  output logic                 res_valid,
  input  logic                 res_ready
);

  localparam logic [ADDR_W-1:0] RL7    = ADDR_W'(ROW_LENGTH);
  localparam logic [ADDR_W:0]   DEPTH8 = (ADDR_W + 1)'(RAM_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } clc_state_t;

  clc_state_t state_r, state_nxt;

  logic [2:0]  func_r;
  logic [7:0]  bus_r;
  logic [1:0]  vrow_r;
  logic [5:0]  vcol_r;

  logic [5:0]  col_r, col_nxt;
  logic        line_r, line_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] busy_r, busy_nxt;
  logic [15:0] short_r, clrt_r;
  logic [7:0]  rd_r, rd_nxt;
  logic        from_mem_r, from_mem_nxt;
  logic        addr_ok_r, addr_ok_nxt;

  logic              wide;
  logic [7:0]        wbyte;
  logic              wdone;
  logic [ADDR_W-1:0] cur_addr, fetch_addr;
  logic              cur_ok, fetch_ok;
  logic [5:0]        col_inc;
  logic [ADDR_W-1:0] modv;
  logic [7:0]        status;

  assign wide  = flags_r[FL_WIDE];
  assign wbyte = wide ? bus_r : {hold_r[3:0], bus_r[7:4]};
  // narrow bus completes on the second nibble, while the phase is 0 (it then returns to 1)
  assign wdone = wide | ~phase_r;

  assign cur_addr = line_r ? (RL7 + {1'b0, col_r}) : {1'b0, col_r};
  assign cur_ok   = {1'b0, cur_addr} < DEPTH8;
  assign fetch_addr = vrow_r[0] ? (RL7 + {1'b0, vcol_r}) : {1'b0, vcol_r};
  assign fetch_ok   = !vrow_r[1] && ({1'b0, vcol_r} < RL7) &&
                      ({1'b0, fetch_addr} < DEPTH8);

  assign col_inc = (({1'b0, col_r} + 7'd1) == RL7) ? 6'd0 : col_r + 6'd1;
  assign status  = {busy_r != 16'd0, line_r, col_r};

  // column of a set-address command, modulo the row length
  always_comb begin
    modv = {1'b0, wbyte[5:0]};
    for (int k = 0; k < 8; k++) begin
      if (modv >= RL7) begin
        modv = modv - RL7;
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    col_nxt      = col_r;
    line_nxt     = line_r;
    flags_nxt    = flags_r;
    phase_nxt    = phase_r;
    hold_nxt     = hold_r;
    busy_nxt     = busy_r;
    rd_nxt       = 8'd0;
    from_mem_nxt = 1'b0;
    addr_ok_nxt  = 1'b0;
    mem_req       = '0;
    mem_req.addr  = cur_addr;
    mem_req.wdata = wbyte;
    if (state_r == ST_EXEC) begin
      unique case (func_r)
        FN_CMD: begin
          if (!wide) begin
            hold_nxt  = wbyte;
            phase_nxt = ~phase_r;
          end
          if (wdone) begin
            priority if (wbyte[7]) begin
              col_nxt  = modv[5:0];
              line_nxt = wbyte[6];
              if (busy_r == 16'd0) busy_nxt = short_r;
            end else if (wbyte[6]) begin
              // glyph address: glyph RAM is not stored, nothing visible
            end else if (wbyte[5]) begin
              flags_nxt = {flags_r[FL_BLINK:FL_DISP], wbyte[2], wbyte[3], wbyte[4]};
              if (!wbyte[4]) phase_nxt = 1'b1;
              if (busy_r == 16'd0) busy_nxt = short_r;
            end else if (wbyte[4]) begin
              // shift: ignore
            end else if (wbyte[3]) begin
              flags_nxt = {wbyte[0], wbyte[1], wbyte[2], flags_r[FL_BIG:FL_WIDE]};
            end else if (wbyte[2]) begin
              // entry mode: ignore
            end else if (wbyte[1]) begin
              col_nxt  = 6'd0;
              line_nxt = 1'b0;
            end else if (wbyte[0]) begin
              mem_req.clr = 1'b1;
              if (busy_r == 16'd0) busy_nxt = clrt_r;
            end else begin
              // null command
            end
          end
        end
        FN_DATA_WR: begin
          if (!wide) begin
            hold_nxt  = wbyte;
            phase_nxt = ~phase_r;
          end
          mem_req.wr_en = wdone & cur_ok;
          // advance condition matches write completion
          if (wdone) col_nxt = col_inc;
        end
        FN_STATUS: begin
          if (wide) begin
            rd_nxt = status;
          end else begin
            phase_nxt = ~phase_r;
            rd_nxt    = phase_r ? {status[3:0], 4'd0} : status;
          end
        end
        FN_DATA_RD: begin
          mem_req.rd_en = 1'b1;
          from_mem_nxt  = 1'b1;
          addr_ok_nxt   = cur_ok;
          if (wide || phase_r) col_nxt = col_inc;
        end
        FN_TICK: begin
          if (busy_r != 16'd0) busy_nxt = busy_r - 16'd1;
        end
        FN_FETCH: begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = fetch_addr;
          from_mem_nxt  = 1'b1;
          addr_ok_nxt   = fetch_ok;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= 6'd0;
      line_r  <= 1'b0;
      flags_r <= FLAGS_RST;
      phase_r <= 1'b1;
      hold_r  <= 8'd0;
      busy_r  <= 16'd0;
      short_r <= SHORT_BUSY_RST;
      clrt_r  <= CLEAR_BUSY_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        col_r   <= col_nxt;
        line_r  <= line_nxt;
        flags_r <= flags_nxt;
        phase_r <= phase_nxt;
        hold_r  <= hold_nxt;
        busy_r  <= busy_nxt;
      end
      if (cfg_we && cfg_index == CFG_SHORT_BUSY) short_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_CLEAR_BUSY) clrt_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      bus_r  <= in_bus_data;
      vrow_r <= in_view_row;
      vcol_r <= in_view_col;
    end
    if (state_r == ST_EXEC) begin
      rd_r       <= rd_nxt;
      from_mem_r <= from_mem_nxt;
      addr_ok_r  <= addr_ok_nxt;
    end
  end

  assign res_valid           = (state_r == ST_RESP);
  assign res.read_data       = from_mem_r ? (addr_ok_r ? mem_rdata : 8'd0) : rd_r;
  assign res.busy_res        = (busy_r != 16'd0);
  assign res.display_enabled = flags_r[FL_DISP];
  assign res.cursor_shown    = flags_r[FL_CURS];
  assign res.cursor_blinks   = flags_r[FL_BLINK];
  assign res.wide_bus        = flags_r[FL_WIDE];
  assign res.two_rows        = flags_r[FL_TWO];
  assign res.big_font        = flags_r[FL_BIG];

endmodule

// ===== design/char_lcd_controller.sv =====
// Top level of the character LCD controller: core, display RAM and
// the output register. Depends on clc_pkg, clc_core and clc_dram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one bus transaction: command
//   write, data write, status read, data read, timer tick or display fetch.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   input transaction: read byte, busy flag and the mode flags after it.
//   Config channel (cfg_valid/cfg_ready, always ready) writes the short
//   and clear busy tick counts; write only while the block is idle.
// Timing:
//   An item is accepted in the idle state, executed in the next cycle
//   (display RAM read or write issued there) and its result is formed in
//   the respond state from the registered RAM data. The core takes no new
//   item until that result has been taken from the respond state, as set
//   by the idle/execute/respond sequence of the core.
//   Clear display invalidates all cells at once.
// Reset (rst_n low, synchronous): cursor home, 8-bit bus mode, busy count
//   zero, RAM reads row 0 as 0xff and row 1 as 0x00 until written.
// Stall: a result waits in the output register; the next item is still
//   taken and executed, then holds until the register frees.
`timescale 1ns / 1ps

module char_lcd_controller import clc_pkg::*; #(
  parameter int ROW_LENGTH = ROW_LENGTH_DEF,
  parameter int RAM_DEPTH  = RAM_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  input  logic [7:0]           in_bus_data,
  input  logic [1:0]           in_view_row,
  input  logic [5:0]           in_view_col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_data,
  output logic                 out_busy_res,
  output logic                 out_display_enabled,
  output logic                 out_cursor_shown,
  output logic                 out_cursor_blinks,
  output logic                 out_wide_bus,
  output logic                 out_two_rows,
  output logic                 out_big_font,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  clc_mem_req_t mem_req;
  logic [7:0]   mem_rdata;
  clc_res_t     res;
  logic         res_valid;
  logic         res_ready;
  logic         out_valid_r;
  clc_res_t     out_r;

  assign cfg_ready = 1'b1;

  clc_core #(
    .ROW_LENGTH (ROW_LENGTH),
    .RAM_DEPTH  (RAM_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_bus_data (in_bus_data),
    .in_view_row (in_view_row),
    .in_view_col (in_view_col),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res         (res),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

  clc_dram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_dram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_r.read_data;
  assign out_busy_res        = out_r.busy_res;
  assign out_display_enabled = out_r.display_enabled;
  assign out_cursor_shown    = out_r.cursor_shown;
  assign out_cursor_blinks   = out_r.cursor_blinks;
  assign out_wide_bus        = out_r.wide_bus;
  assign out_two_rows        = out_r.two_rows;
  assign out_big_font        = out_r.big_font;

endmodule
